### rtl/osdtp_pkg.sv
// Shared types, constants and the 5x7 font for the OSD text pixel generator.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none
package osdtp_pkg;

  // Limits and font geometry
  localparam int unsigned MAX_CHARS  = 16;
  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_GAP  = 4;
  localparam int unsigned CODE_COLON = 10;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_GLYPH_SCALE  = 3'd2,
    REG_TEXT_LENGTH  = 3'd3,
    REG_TEXT_CODES   = 3'd4,
    REG_FG_COLOR     = 3'd5
  } cfg_reg_e;

  // Input and result words
  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic        lit;
    logic [31:0] pixel_argb;
  } pix_out_t;

  // Programmed register contents
  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [4:0]  glyph_scale;
    logic [4:0]  text_length;
    logic [63:0] text_codes;
    logic [31:0] fg_color;
  } cfg_t;

  // Text placement derived from the registers
  typedef struct packed {
    logic        en;     // something can be drawn at all
    logic [12:0] w;      // clamped frame width
    logic [12:0] h;      // clamped frame height
    logic [4:0]  len;    // clamped slot count
    logic [4:0]  s;      // dot size
    logic [7:0]  gw;     // glyph width
    logic [7:0]  gh;     // glyph height
    logic [7:0]  cw;     // slot pitch
    logic [11:0] y0;     // top text row
    logic [11:0] x0;     // left text column
  } geom_t;

  // Word leaving the locate stages
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [11:0] px;
    logic [11:0] dx;
    logic [1:0]  row_hi;
    logic [7:0]  row_rem;
  } loc_t;

  // Word leaving the slot divider
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic [11:0] px;
    logic [3:0]  slot;
    logic [7:0]  rem;
    logic [2:0]  row;
  } slot_t;

  // Font: 11 glyphs of 7 rows, bit 4 is the leftmost column
  localparam logic [0:10][0:6][4:0] FONT_ROWS = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h06, 5'h02, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    '{5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00}
  };

  // Look up one font row; blank codes and rows past the glyph read as empty
  function automatic logic [4:0] font_row(input logic [3:0] code, input logic [2:0] row);
    logic [4:0] bits;
    bits = 5'd0;
    if ((code <= 4'(CODE_COLON)) && (row < 3'(GLYPH_ROWS))) begin
      bits = FONT_ROWS[code][row];
    end
    return bits;
  endfunction

endpackage
`default_nettype wire

### rtl/osdtp_geom.sv
// Derives text placement (clamps, glyph sizes, origin) from the registers.
// Two register levels; depends on osdtp_pkg.
`default_nettype none
module osdtp_geom (
  input  wire logic           clk_i,
  input  wire osdtp_pkg::cfg_t cfg_i,
  output osdtp_pkg::geom_t    geom_o
);
  import osdtp_pkg::*;

  // First level
  logic [12:0] w_d, w_q, h_d, h_q;
  logic [4:0]  len_d, len_q, s_q;
  logic [7:0]  gw_d, gw_q, gh_d, gh_q, cw_d, cw_q;
  logic [11:0] prod_d, prod_q, y0_d, y0_q;
  logic        en_d, en_q;
  logic [12:0] prod_full;
  logic        tall;
  // Second level
  logic [12:0] total, total_c;
  logic [11:0] x0_d, x0_q;

  // Clamp the registers and size one glyph
  always_comb begin
    w_d   = (cfg_i.frame_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_i.frame_width;
    h_d   = (cfg_i.frame_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg_i.frame_height;
    len_d = (cfg_i.text_length > 5'(MAX_CHARS)) ? 5'(MAX_CHARS) : cfg_i.text_length;
    gw_d  = 8'({cfg_i.glyph_scale, 2'b00}) + 8'(cfg_i.glyph_scale);
    gh_d  = 8'({cfg_i.glyph_scale, 3'b000}) - 8'(cfg_i.glyph_scale);
    cw_d  = gw_d + 8'(GLYPH_GAP);
    prod_full = 13'(len_d) * 13'(cw_d);
    prod_d = prod_full[11:0];
    tall  = 13'(gh_d) > h_d;
    y0_d  = 12'((h_d - 13'(gh_d)) >> 1);
    en_d  = (w_d != 13'd0) && (h_d != 13'd0) && (len_d != 5'd0) &&
            (cfg_i.glyph_scale != 5'd0) && !tall;
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    h_q    <= h_d;
    len_q  <= len_d;
    s_q    <= cfg_i.glyph_scale;
    gw_q   <= gw_d;
    gh_q   <= gh_d;
    cw_q   <= cw_d;
    prod_q <= prod_d;
    y0_q   <= y0_d;
    en_q   <= en_d;
  end

  // Clamp the line width to the frame and center it
  always_comb begin
    total   = 13'(prod_q) - 13'(GLYPH_GAP);
    total_c = (total > w_q) ? w_q : total;
    x0_d    = 12'((w_q - total_c) >> 1);
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d;
  end

  assign geom_o = '{en: en_q, w: w_q, h: h_q, len: len_q, s: s_q, gw: gw_q, gh: gh_q,
                    cw: cw_q, y0: y0_q, x0: x0_q};

endmodule
`default_nettype wire

### rtl/osdtp_locate.sv
// Stages 1-3: capture the pixel, window it against the text box, start the row divide.
// Depends on osdtp_pkg.
`default_nettype none
module osdtp_locate (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire osdtp_pkg::pix_in_t pix_i,
  input  wire osdtp_pkg::geom_t   geom_i,
  output osdtp_pkg::loc_t     loc_o
);
  import osdtp_pkg::*;

  logic        v1_q, v2_q, v3_q;
  logic [11:0] px1_q, py1_q, px2_q, px3_q, dx3_q;
  logic        ok2_d, ok2_q, ok3_q;
  logic [11:0] dy_full;
  logic [7:0]  dy2_q;
  logic [7:0]  s4, s2, r_a, r_b;
  logic        b2, b1;
  logic [1:0]  row_hi_q;
  logic [7:0]  row_rem_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Window the pixel against frame and text rows
  always_comb begin
    dy_full = py1_q - geom_i.y0;
    ok2_d = geom_i.en && (13'(px1_q) < geom_i.w) && (13'(py1_q) < geom_i.h) &&
            (py1_q >= geom_i.y0) && (dy_full < 12'(geom_i.gh));
  end

  // Two steps of the row divide
  always_comb begin
    s4  = 8'({geom_i.s, 2'b00});
    s2  = 8'({geom_i.s, 1'b0});
    b2  = dy2_q >= s4;
    r_a = b2 ? dy2_q - s4 : dy2_q;
    b1  = r_a >= s2;
    r_b = b1 ? r_a - s2 : r_a;
  end

  always_ff @(posedge clk_i) begin
    px1_q     <= pix_i.pixel_x;
    py1_q     <= pix_i.pixel_y;
    px2_q     <= px1_q;
    ok2_q     <= ok2_d;
    dy2_q     <= dy_full[7:0];
    px3_q     <= px2_q;
    ok3_q     <= ok2_q && (px2_q >= geom_i.x0);
    dx3_q     <= px2_q - geom_i.x0;
    row_hi_q  <= {b2, b1};
    row_rem_q <= r_b;
  end

  assign loc_o = '{valid: v3_q, ok: ok3_q, px: px3_q, dx: dx3_q,
                   row_hi: row_hi_q, row_rem: row_rem_q};

endmodule
`default_nettype wire

### rtl/osdtp_slot_div.sv
// Stages 4-5: restoring divide of the column offset by the slot pitch, two bits a stage.
// Also finishes the row divide. Depends on osdtp_pkg.
`default_nettype none
module osdtp_slot_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire osdtp_pkg::loc_t  loc_i,
  input  wire osdtp_pkg::geom_t geom_i,
  output osdtp_pkg::slot_t   slot_o
);
  import osdtp_pkg::*;

  logic        v4_q, v5_q;
  logic        ok4_q, ok5_q;
  logic [11:0] px4_q, px5_q;
  logic [11:0] c16, c8, c4, c2, c1;
  logic [11:0] r4a, r4b, r5a, r5b;
  logic        q3, q2, q1, q0;
  logic [11:0] rem4_q;
  logic [1:0]  qh4_q;
  logic [2:0]  row4_d, row4_q, row5_q;
  logic [3:0]  slot5_q;
  logic [7:0]  rem5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v4_q <= loc_i.valid;
      v5_q <= v4_q;
    end
  end

  // Multiples of the pitch are shifts
  always_comb begin
    c16 = 12'({geom_i.cw, 4'b0000});
    c8  = 12'({geom_i.cw, 3'b000});
    c4  = 12'({geom_i.cw, 2'b00});
    c2  = 12'({geom_i.cw, 1'b0});
    c1  = 12'(geom_i.cw);
  end

  // Upper quotient bits and last row step
  always_comb begin
    q3  = loc_i.dx >= c8;
    r4a = q3 ? loc_i.dx - c8 : loc_i.dx;
    q2  = r4a >= c4;
    r4b = q2 ? r4a - c4 : r4a;
    row4_d = {loc_i.row_hi, (loc_i.row_rem >= 8'(geom_i.s))};
  end

  // Lower quotient bits
  always_comb begin
    q1  = rem4_q >= c2;
    r5a = q1 ? rem4_q - c2 : rem4_q;
    q0  = r5a >= c1;
    r5b = q0 ? r5a - c1 : r5a;
  end

  always_ff @(posedge clk_i) begin
    px4_q   <= loc_i.px;
    ok4_q   <= loc_i.ok && (loc_i.dx < c16);
    rem4_q  <= r4b;
    qh4_q   <= {q3, q2};
    row4_q  <= row4_d;
    px5_q   <= px4_q;
    ok5_q   <= ok4_q;
    slot5_q <= {qh4_q, q1, q0};
    rem5_q  <= r5b[7:0];
    row5_q  <= row4_q;
  end

  assign slot_o = '{valid: v5_q, ok: ok5_q, px: px5_q, slot: slot5_q,
                    rem: rem5_q, row: row5_q};

endmodule
`default_nettype wire

### rtl/osdtp_glyph.sv
// Stages 6-7: slot checks, code and font lookup, column divide, colored result word.
// Depends on osdtp_pkg.
`default_nettype none
module osdtp_glyph (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire osdtp_pkg::slot_t slot_i,
  input  wire osdtp_pkg::geom_t geom_i,
  input  wire osdtp_pkg::cfg_t  cfg_i,
  output logic                res_valid_o,
  output osdtp_pkg::pix_out_t res_o
);
  import osdtp_pkg::*;

  logic        v6_q, v7_q;
  logic        ok6_d, ok6_q;
  logic [3:0]  code;
  logic [5:0]  code_base;
  logic [12:0] slot_end;
  logic [7:0]  s4, s2, s1;
  logic        c2_d, c2_q, c1, c0;
  logic [7:0]  r6_d, r6_q, r7a;
  logic [4:0]  bits6_q;
  logic [2:0]  col;
  logic        dot;
  logic        lit_q;
  logic [31:0] argb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v6_q <= slot_i.valid;
      v7_q <= v6_q;
    end
  end

  always_comb begin
    s4 = 8'({geom_i.s, 2'b00});
    s2 = 8'({geom_i.s, 1'b0});
    s1 = 8'(geom_i.s);
  end

  // Drop gaps, unused slots and glyphs that overrun the frame; fetch the code
  always_comb begin
    slot_end  = 13'(slot_i.px) - 13'(slot_i.rem) + 13'(geom_i.gw);
    ok6_d     = slot_i.ok && (5'(slot_i.slot) < geom_i.len) && (slot_i.rem < geom_i.gw) &&
                (slot_end <= geom_i.w);
    code_base = {slot_i.slot, 2'b00};
    code      = cfg_i.text_codes[code_base +: 4];
    c2_d      = slot_i.rem >= s4;
    r6_d      = c2_d ? slot_i.rem - s4 : slot_i.rem;
  end

  // Finish the column divide and pick the dot
  always_comb begin
    c1  = r6_q >= s2;
    r7a = c1 ? r6_q - s2 : r6_q;
    c0  = r7a >= s1;
    col = {c2_q, c1, c0};
    dot = (col <= 3'(GLYPH_COLS - 1)) ? bits6_q[3'(GLYPH_COLS - 1) - col] : 1'b0;
  end

  always_ff @(posedge clk_i) begin
    ok6_q   <= ok6_d;
    bits6_q <= font_row(code, slot_i.row);
    c2_q    <= c2_d;
    r6_q    <= r6_d;
    lit_q   <= ok6_q && dot;
    argb_q  <= (ok6_q && dot) ? cfg_i.fg_color : 32'd0;
  end

  assign res_valid_o = v7_q;
  assign res_o       = '{lit: lit_q, pixel_argb: argb_q};

endmodule
`default_nettype wire

### rtl/osd_text_pixel_generator_top.sv
// OSD text pixel generator: one pixel per clock, seven-stage pipeline with no
// back-pressure. A pixel taken when start is high gives its result on res_o,
// marked by res_valid_o, once it has passed every stage; busy never rises, so a
// new pixel may be started in every cycle. The receiver cannot stall the
// result and must take it in the cycle it is shown. Register writes take
// effect for pixels started in the next cycle onward; the registered placement
// logic settles while the first pipeline stages run.
// Depends on osdtp_pkg and the osdtp_* stage modules.
`default_nettype none
module osd_text_pixel_generator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire osdtp_pkg::pix_in_t                pix_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [osdtp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [osdtp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                                   res_valid_o,
  output osdtp_pkg::pix_out_t                    res_o
);
  import osdtp_pkg::*;

  cfg_t  cfg_q;
  geom_t geom;
  loc_t  loc;
  slot_t slot;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= 13'd640;
      cfg_q.frame_height <= 13'd480;
      cfg_q.glyph_scale  <= 5'd1;
      cfg_q.text_length  <= 5'd0;
      cfg_q.text_codes   <= 64'd0;
      cfg_q.fg_color     <= 32'hFFFF_FF00;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[12:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        REG_GLYPH_SCALE:  cfg_q.glyph_scale  <= cfg_data_i[4:0];
        REG_TEXT_LENGTH:  cfg_q.text_length  <= cfg_data_i[4:0];
        REG_TEXT_CODES:   cfg_q.text_codes   <= cfg_data_i;
        REG_FG_COLOR:     cfg_q.fg_color     <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Pipeline never holds off a word
  assign busy = 1'b0;

  osdtp_geom u_geom (
    .clk_i  (clk_i),
    .cfg_i  (cfg_q),
    .geom_o (geom)
  );

  osdtp_locate u_locate (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .pix_i      (pix_i),
    .geom_i     (geom),
    .loc_o      (loc)
  );

  osdtp_slot_div u_slot_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .loc_i  (loc),
    .geom_i (geom),
    .slot_o (slot)
  );

  osdtp_glyph u_glyph (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .slot_i      (slot),
    .geom_i      (geom),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
`default_nettype wire

### bench/tb_osd_text_pixel_generator_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the OSD text pixel generator: drives pixel words and
// register writes, predicts every result word, and compares it field by field.
// Depends on osdtp_pkg and the osd_text_pixel_generator_top RTL.
module tb_osd_text_pixel_generator_top;
  import osdtp_pkg::*;

  localparam int unsigned PIPE_DEPTH   = 7;
  localparam int unsigned SETTLE_CYC   = PIPE_DEPTH + 3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned BLANK_FIRST  = 11;
  localparam int unsigned BLANK_LAST   = 15;
  localparam int unsigned RAND_PHASES  = 14;
  localparam int unsigned PHASE_PIXELS = 32;

  // Register image as the bench programs it
  typedef struct packed {
    logic [12:0] fw;
    logic [12:0] fh;
    logic [4:0]  scale;
    logic [4:0]  slots;
    logic [63:0] codes;
    logic [31:0] color;
  } overlay_regs_t;

  // Tracks the programmed registers and the queue of predicted result words
  class overlay_board;
    logic [12:0] fw;
    logic [12:0] fh;
    logic [4:0]  scale;
    logic [4:0]  slots;
    logic [63:0] codes;
    logic [31:0] color;
    pix_out_t    expected_words[$];
    int unsigned failures;

    function new();
      fw       = 13'd640;
      fh       = 13'd480;
      scale    = 5'd1;
      slots    = 5'd0;
      codes    = '0;
      color    = 32'hFFFF_FF00;
      failures = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] data);
      case (idx)
        REG_FRAME_WIDTH:  fw = data[12:0];
        REG_FRAME_HEIGHT: fh = data[12:0];
        REG_GLYPH_SCALE:  scale = data[4:0];
        REG_TEXT_LENGTH:  slots = data[4:0];
        REG_TEXT_CODES:   codes = data;
        REG_FG_COLOR:     color = data[31:0];
        default: ;
      endcase
    endfunction

    // One 5-dot row of a glyph, leftmost dot in bit 4
    function logic [4:0] glyph_row(int unsigned code, int unsigned row);
      logic [34:0] rows;
      case (code)
        0:          rows = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
        1:          rows = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
        2:          rows = {5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F};
        3:          rows = {5'h1F, 5'h02, 5'h04, 5'h06, 5'h02, 5'h11, 5'h0E};
        4:          rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
        5:          rows = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
        6:          rows = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
        7:          rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
        8:          rows = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
        9:          rows = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
        CODE_COLON: rows = {5'h00, 5'h00, 5'h04, 5'h00, 5'h04, 5'h00, 5'h00};
        default:    rows = '0;
      endcase
      return rows[34 - 5 * row -: 5];
    endfunction

    // Decide whether a pixel falls on a drawn dot of the centered text line
    function bit glyph_dot_lit(int unsigned px, int unsigned py);
      int unsigned w, h, n, s, gw, gh, pitch, span, left, top;
      int unsigned slot, offs, code, row, col;
      logic [4:0]  dots;
      w = (fw > MAX_DIM) ? MAX_DIM : fw;
      h = (fh > MAX_DIM) ? MAX_DIM : fh;
      n = (slots > MAX_CHARS) ? MAX_CHARS : slots;
      s = scale;
      if (w == 0 || h == 0 || n == 0 || s == 0) return 1'b0;
      if (px >= w || py >= h) return 1'b0;
      gw    = GLYPH_COLS * s;
      gh    = GLYPH_ROWS * s;
      pitch = gw + GLYPH_GAP;
      span  = n * pitch - GLYPH_GAP;
      if (span > w) span = w;
      if (gh > h) return 1'b0;
      left = (w - span) / 2;
      top  = (h - gh) / 2;
      if (px < left || py < top) return 1'b0;
      if (py - top >= gh) return 1'b0;
      slot = (px - left) / pitch;
      offs = (px - left) % pitch;
      if (slot >= n || offs >= gw) return 1'b0;
      // drop a glyph that would run past the right frame edge
      if (left + slot * pitch + gw > w) return 1'b0;
      code = 32'((codes >> (4 * slot)) & 64'hF);
      if (code > CODE_COLON) return 1'b0;
      row  = (py - top) / s;
      col  = offs / s;
      dots = glyph_row(code, row);
      return dots[4 - col];
    endfunction

    function void note_pixel(pix_in_t p);
      pix_out_t want;
      want.lit        = glyph_dot_lit(p.pixel_x, p.pixel_y);
      want.pixel_argb = want.lit ? color : '0;
      expected_words.push_back(want);
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: lit %0d argb %08h",
               got.lit, got.pixel_argb);
        failures++;
        return;
      end
      want = expected_words.pop_front();
      if (got.lit !== want.lit) begin
        $error("lit: expected %0d, got %0d", want.lit, got.lit);
        failures++;
      end
      if (got.pixel_argb !== want.pixel_argb) begin
        $error("pixel_argb: expected %08h, got %08h", want.pixel_argb, got.pixel_argb);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pix_in_t               pix_i;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  res_valid_o;
  pix_out_t              res_o;

  overlay_board  board;
  bit            no_gaps;
  int unsigned   stall_cycles;

  osd_text_pixel_generator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pix_i       (pix_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Observe accepted pixel words, result words and register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_pixel(pix_i);
      if (res_valid_o) board.check_pixel(res_o);
      if (cfg_we_i) board.write_reg(cfg_reg_e'(cfg_idx_i), cfg_data_i);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL osd_text_pixel_generator_top");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic overlay_regs_t make_regs(int unsigned w, int unsigned h,
                                              int unsigned s, int unsigned n,
                                              logic [63:0] c, logic [31:0] fg);
    overlay_regs_t r;
    r.fw    = 13'(w);
    r.fh    = 13'(h);
    r.scale = 5'(s);
    r.slots = 5'(n);
    r.codes = c;
    r.color = fg;
    return r;
  endfunction

  // Frame dimension: mostly in range, now and then zero or oversized
  function automatic int unsigned random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 0;
    if (pick == 1) return $urandom_range(MAX_DIM + 1, 8191);
    if (pick < 6) return $urandom_range(1, 100);
    return $urandom_range(101, MAX_DIM);
  endfunction

  function automatic overlay_regs_t random_regs();
    overlay_regs_t r;
    int unsigned   pick;
    r.fw  = 13'(random_dim());
    r.fh  = 13'(random_dim());
    pick  = $urandom_range(0, 19);
    r.scale = (pick == 0) ? 5'd0 : (pick < 3) ? 5'($urandom_range(9, 31))
                                              : 5'($urandom_range(1, 8));
    pick  = $urandom_range(0, 19);
    r.slots = (pick == 0) ? 5'd0 : (pick == 1) ? 5'($urandom_range(MAX_CHARS + 1, 31))
                                               : 5'($urandom_range(1, MAX_CHARS));
    if ($urandom_range(0, 9) == 0) begin
      r.codes = {$urandom, $urandom};
    end else begin
      for (int k = 0; k < 16; k++) begin
        r.codes[4*k +: 4] = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, CODE_COLON))
                                                         : 4'($urandom_range(BLANK_FIRST,
                                                                             BLANK_LAST));
      end
    end
    r.color = $urandom;
    return r;
  endfunction

  // Aim most pixels at the text box, some elsewhere in the frame, a few anywhere
  function automatic pix_in_t pick_pixel(overlay_regs_t r);
    pix_in_t     p;
    int unsigned pick, w, h, s, n, gh, span, left, top;
    pick = $urandom_range(0, 99);
    w = (r.fw > MAX_DIM) ? MAX_DIM : r.fw;
    h = (r.fh > MAX_DIM) ? MAX_DIM : r.fh;
    s = r.scale;
    n = (r.slots > MAX_CHARS) ? MAX_CHARS : r.slots;
    p.pixel_x = 12'($urandom);
    p.pixel_y = 12'($urandom);
    if (pick < 10 || w == 0 || h == 0) return p;
    p.pixel_x = 12'($urandom_range(0, w - 1));
    p.pixel_y = 12'($urandom_range(0, h - 1));
    if (pick < 30 || s == 0 || n == 0) return p;
    gh   = GLYPH_ROWS * s;
    span = n * (GLYPH_COLS * s + GLYPH_GAP) - GLYPH_GAP;
    if (span > w) span = w;
    left = (w - span) / 2;
    top  = (gh <= h) ? (h - gh) / 2 : 0;
    if (gh > h) gh = h;
    p.pixel_x = 12'(left + $urandom_range(0, span - 1));
    p.pixel_y = 12'(top + $urandom_range(0, gh - 1));
    return p;
  endfunction

  // Drive one pixel word; idle first at random, hold until accepted
  task automatic send_pixel(pix_in_t p);
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    pix_i = p;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    hold_until_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
  endtask

  // Program every register while the pipeline is empty
  task automatic program_regs(overlay_regs_t r);
    write_reg(REG_FRAME_WIDTH,  64'(r.fw));
    write_reg(REG_FRAME_HEIGHT, 64'(r.fh));
    write_reg(REG_GLYPH_SCALE,  64'(r.scale));
    write_reg(REG_TEXT_LENGTH,  64'(r.slots));
    write_reg(REG_TEXT_CODES,   r.codes);
    write_reg(REG_FG_COLOR,     64'(r.color));
    cfg_we_i = 1'b0;
  endtask

  // Short check of one setting: text box, a frame corner, text box again
  task automatic directed_case(overlay_regs_t r, bit far_corner);
    pix_in_t corner;
    corner.pixel_x = far_corner ? 12'hFFF : 12'h000;
    corner.pixel_y = far_corner ? 12'hFFF : 12'h000;
    program_regs(r);
    send_pixel(pick_pixel(r));
    send_pixel(corner);
    send_pixel(pick_pixel(r));
    wait_for_results();
  endtask

  task automatic random_phase(overlay_regs_t r, int unsigned pause_at);
    program_regs(r);
    for (int unsigned i = 0; i < PHASE_PIXELS; i++) begin
      // now and then let the pipeline run dry mid-stream
      if (i == pause_at || $urandom_range(0, 49) == 0) hold_until_drained();
      send_pixel(pick_pixel(r));
    end
    wait_for_results();
  endtask

  initial begin
    board      = new();
    no_gaps    = 1'b0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    pix_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_FRAME_WIDTH;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty text at reset values
    directed_case(make_regs(640, 480, 1, 0, 64'h0, 32'hFFFF_FF00), 1'b0);
    // all ten digits and the colon
    directed_case(make_regs(640, 480, 1, 11, 64'h0000_0A98_7654_3210, 32'hFFFF_FFFF), 1'b1);
    // zero scale draws nothing
    directed_case(make_regs(640, 480, 0, 5, 64'h0000_0000_0004_3210, 32'h1234_5678), 1'b0);
    // zero frame width, then zero frame height
    directed_case(make_regs(0, 480, 2, 4, 64'h0000_0000_0000_5A12, 32'h8765_4321), 1'b1);
    directed_case(make_regs(640, 0, 2, 4, 64'h0000_0000_0000_5A12, 32'h8765_4321), 1'b0);
    // oversized frame, largest dots, full text
    directed_case(make_regs(8191, 8191, 31, 16, 64'h8888_0000_8888_0000, 32'h0000_0000), 1'b1);
    // long text clamped to a narrow frame, blank codes among the slots
    directed_case(make_regs(100, 64, 4, 31, 64'hFEDC_BA98_7654_8FB1, 32'hA5A5_5A5A), 1'b0);
    // glyph taller than the frame
    directed_case(make_regs(640, 20, 3, 4, 64'h0000_0000_0000_8888, 32'hFFFF_FFFF), 1'b1);
    // one-pixel frame
    directed_case(make_regs(1, 1, 1, 1, 64'h0000_0000_0000_0008, 32'hFFFF_FFFF), 1'b0);

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      no_gaps = (ph == 3);
      random_phase(random_regs(), (ph == 0) ? PHASE_PIXELS / 2 : PHASE_PIXELS);
    end
    no_gaps = 1'b0;

    if (board.pending() != 0) $error("%0d result words never arrived", board.pending());
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS osd_text_pixel_generator_top");
    end else begin
      $display("FAIL osd_text_pixel_generator_top");
    end
    $finish;
  end

endmodule
